[rtl/hmtq_pkg.sv]
// shared types, constants and codes for the heightmap edit and query block
`timescale 1ns / 1ps
`default_nettype none

package hmtq_pkg;

    // grid geometry
    localparam int MAX_SIDE  = 63;
    localparam int SIDE_W    = 6;
    localparam int NUM_VERTS = (MAX_SIDE + 1) * (MAX_SIDE + 1);
    localparam int ADDR_W    = $clog2(NUM_VERTS);
    localparam int HEIGHT_W  = 24;
    localparam int COORD_W   = 16;

    // height limits in Q15.8
    localparam logic [HEIGHT_W-1:0] H_MAX = 24'h7FFFFF;
    localparam logic [HEIGHT_W-1:0] H_MIN = 24'h800000;

    // configuration register indexes
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_LENGTH = 1'b1;

    // item kinds
    localparam logic KIND_RAISE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
    localparam logic [1:0] STATUS_SAT     = 2'd2;

    // input item
    typedef struct packed {
        logic                       kind;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_z;
        logic signed [HEIGHT_W-1:0] delta;
    } hmtq_cmd_t;

    // result item
    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height_out;
        logic [1:0]                 status;
    } hmtq_res_t;

    // decoded addresses and weights for one item
    typedef struct packed {
        logic              outside;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic [ADDR_W-1:0] addr_c;
        logic [8:0]        w_b;
        logic [8:0]        w_c;
    } hmtq_dec_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RAISE,
        S_QB,
        S_QC,
        S_QM1,
        S_QM2,
        S_QSUM,
        S_DONE
    } hmtq_state_t;

endpackage

`default_nettype wire

[rtl/hmtq_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module hmtq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one access per cycle: write or registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

[rtl/hmtq_decode.sv]
// bounds check, vertex addresses and triangle weights for one item
`timescale 1ns / 1ps
`default_nettype none

module hmtq_decode (
    input  wire hmtq_pkg::hmtq_cmd_t               cmd,
    input  wire logic [hmtq_pkg::SIDE_W-1:0]       grid_width,
    input  wire logic [hmtq_pkg::SIDE_W-1:0]       grid_length,
    output hmtq_pkg::hmtq_dec_t                    dec
);

    logic [6:0]                  xi;
    logic [6:0]                  zi;
    logic [7:0]                  fx;
    logic [7:0]                  fz;
    logic [6:0]                  pitch;
    logic [13:0]                 row_off;
    logic [13:0]                 base_w;
    logic [hmtq_pkg::ADDR_W-1:0] base;
    logic [hmtq_pkg::ADDR_W-1:0] pitch_a;
    logic [8:0]                  fsum;
    logic                        neg;
    logic                        upper;
    logic                        out_raise;
    logic                        out_query;

    // integer and fraction parts
    assign neg = cmd.pos_x[15] | cmd.pos_z[15];
    assign xi  = cmd.pos_x[14:8];
    assign zi  = cmd.pos_z[14:8];
    assign fx  = cmd.pos_x[7:0];
    assign fz  = cmd.pos_z[7:0];

    // row-major base address
    assign pitch   = {1'b0, grid_width} + 7'd1;
    assign row_off = zi * pitch;
    assign base_w  = row_off + {7'b0, xi};
    assign base    = base_w[hmtq_pkg::ADDR_W-1:0];
    assign pitch_a = {{(hmtq_pkg::ADDR_W-7){1'b0}}, pitch};

    // bounds: raise may sit on the last vertex, query needs a whole cell
    assign out_raise = neg || (xi > {1'b0, grid_width}) || (zi > {1'b0, grid_length});
    assign out_query = neg || (xi >= {1'b0, grid_width}) || (zi >= {1'b0, grid_length});

    // triangle pick
    assign fsum  = {1'b0, fx} + {1'b0, fz};
    assign upper = fsum > 9'd256;

    always_comb
    begin
        dec.outside = (cmd.kind == hmtq_pkg::KIND_RAISE) ? out_raise : out_query;
        dec.addr_b  = base + {{(hmtq_pkg::ADDR_W-1){1'b0}}, 1'b1};
        dec.addr_c  = base + pitch_a;
        if (cmd.kind == hmtq_pkg::KIND_QUERY && upper)
        begin
            // far corner anchors the upper triangle
            dec.addr_a = base + pitch_a + {{(hmtq_pkg::ADDR_W-1){1'b0}}, 1'b1};
            dec.w_b    = 9'd256 - {1'b0, fz};
            dec.w_c    = 9'd256 - {1'b0, fx};
        end
        else
        begin
            dec.addr_a = base;
            dec.w_b    = {1'b0, fx};
            dec.w_c    = {1'b0, fz};
        end
    end

endmodule

`default_nettype wire

[rtl/heightmap_edit_and_triangle_query.sv]
// top level: sequencer, vertex ram and interpolation datapath
`timescale 1ns / 1ps
`default_nettype none

// Keeps a 64 x 64 vertex height grid in one single-port ram and serves one
// item at a time. After reset a clearing pass writes zero to all 4096 entries,
// one per cycle, and cmd_stall stays high until it ends (configuration writes
// are taken meanwhile). A raise holds the block through accept, decode and
// read, add and write back, and hand-off; a query holds it through accept,
// three vertex reads from the one ram port, two multiply steps, round and
// saturate, and hand-off; an item outside the grid holds it through accept,
// decode and hand-off. The hand-off cycle repeats while a stalled result
// still occupies the output register. The rate is set by the single ram port
// and the two 25 x 10 multiply steps run in sequence.
// A finished result waits in the output register while the next item is
// accepted; a new result is only handed over once that register is free.
module heightmap_edit_and_triangle_query (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [hmtq_pkg::SIDE_W-1:0]    cfg_data,
    input  wire logic                           cmd_valid,
    output logic                                cmd_stall,
    input  wire hmtq_pkg::hmtq_cmd_t            cmd_data,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output hmtq_pkg::hmtq_res_t                 res_data
);

    hmtq_pkg::hmtq_state_t             state_reg;
    hmtq_pkg::hmtq_state_t             state_next;
    logic [hmtq_pkg::SIDE_W-1:0]       grid_width_reg;
    logic [hmtq_pkg::SIDE_W-1:0]       grid_length_reg;
    logic [hmtq_pkg::ADDR_W-1:0]       clr_cnt_reg;
    hmtq_pkg::hmtq_cmd_t               item_reg;
    hmtq_pkg::hmtq_dec_t               dec;
    hmtq_pkg::hmtq_res_t               pend_reg;
    hmtq_pkg::hmtq_res_t               res_data_reg;
    logic                              res_valid_reg;
    logic signed [23:0]                va_reg;
    logic signed [23:0]                vb_reg;
    logic signed [23:0]                vc_reg;
    logic signed [34:0]                prod_b_reg;
    logic signed [34:0]                prod_c_reg;

    logic                              ram_we;
    logic [hmtq_pkg::ADDR_W-1:0]       ram_addr;
    logic [hmtq_pkg::HEIGHT_W-1:0]     ram_wdata;
    logic [hmtq_pkg::HEIGHT_W-1:0]     ram_rdata;

    logic                              accept;
    logic                              out_free;
    logic                              clr_last;
    logic [24:0]                       rsum;
    logic                              r_ovf;
    logic [hmtq_pkg::HEIGHT_W-1:0]     r_val;
    logic signed [24:0]                diff_b;
    logic signed [24:0]                diff_c;
    logic signed [35:0]                acc;
    logic signed [35:0]                rnd;
    logic                              q_ovf;
    logic [hmtq_pkg::HEIGHT_W-1:0]     q_val;

    // vertex store
    hmtq_ram #(
        .WIDTH (hmtq_pkg::HEIGHT_W),
        .DEPTH (hmtq_pkg::NUM_VERTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // addresses and weights of the held item
    hmtq_decode u_decode (
        .cmd         (item_reg),
        .grid_width  (grid_width_reg),
        .grid_length (grid_length_reg),
        .dec         (dec)
    );

    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign clr_last  = &clr_cnt_reg;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= 6'd63;
            grid_length_reg <= 6'd63;
        end
        else if (cfg_we)
        begin
            if (cfg_index == hmtq_pkg::CFG_GRID_WIDTH)
            begin
                grid_width_reg <= cfg_data;
            end
            else
            begin
                grid_length_reg <= cfg_data;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hmtq_pkg::S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = hmtq_pkg::S_IDLE;
                end
            end
            hmtq_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = hmtq_pkg::S_DECODE;
                end
            end
            hmtq_pkg::S_DECODE:
            begin
                if (dec.outside)
                begin
                    state_next = hmtq_pkg::S_DONE;
                end
                else if (item_reg.kind == hmtq_pkg::KIND_RAISE)
                begin
                    state_next = hmtq_pkg::S_RAISE;
                end
                else
                begin
                    state_next = hmtq_pkg::S_QB;
                end
            end
            hmtq_pkg::S_RAISE: state_next = hmtq_pkg::S_DONE;
            hmtq_pkg::S_QB:    state_next = hmtq_pkg::S_QC;
            hmtq_pkg::S_QC:    state_next = hmtq_pkg::S_QM1;
            hmtq_pkg::S_QM1:   state_next = hmtq_pkg::S_QM2;
            hmtq_pkg::S_QM2:   state_next = hmtq_pkg::S_QSUM;
            hmtq_pkg::S_QSUM:  state_next = hmtq_pkg::S_DONE;
            hmtq_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = hmtq_pkg::S_IDLE;
                end
            end
            default: state_next = hmtq_pkg::S_IDLE;
        endcase
    end

    // ram control and input stall
    always_comb
    begin
        cmd_stall = 1'b1;
        ram_we    = 1'b0;
        ram_addr  = dec.addr_a;
        ram_wdata = r_val;
        case (state_reg)
            hmtq_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            hmtq_pkg::S_IDLE:   cmd_stall = 1'b0;
            hmtq_pkg::S_DECODE: ram_addr  = dec.addr_a;
            hmtq_pkg::S_RAISE:
            begin
                ram_we   = 1'b1;
                ram_addr = dec.addr_a;
            end
            hmtq_pkg::S_QB:     ram_addr  = dec.addr_b;
            hmtq_pkg::S_QC:     ram_addr  = dec.addr_c;
            default:            ram_addr  = dec.addr_a;
        endcase
    end

    // raise: add and saturate
    assign rsum  = {ram_rdata[23], ram_rdata} + {item_reg.delta[23], item_reg.delta};
    assign r_ovf = rsum[24] ^ rsum[23];
    assign r_val = r_ovf ? (rsum[24] ? hmtq_pkg::H_MIN : hmtq_pkg::H_MAX) : rsum[23:0];

    // query: plane sum, round half up, saturate
    assign diff_b = $signed({vb_reg[23], vb_reg}) - $signed({va_reg[23], va_reg});
    assign diff_c = $signed({vc_reg[23], vc_reg}) - $signed({va_reg[23], va_reg});
    assign acc    = $signed({{4{va_reg[23]}}, va_reg, 8'h00})
                  + $signed({prod_b_reg[34], prod_b_reg})
                  + $signed({prod_c_reg[34], prod_c_reg});
    assign rnd    = (acc + 36'sd128) >>> 8;
    assign q_ovf  = rnd[35:23] != {13{rnd[23]}};
    assign q_val  = q_ovf ? (rnd[35] ? hmtq_pkg::H_MIN : hmtq_pkg::H_MAX) : rnd[23:0];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hmtq_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == hmtq_pkg::S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + {{(hmtq_pkg::ADDR_W-1){1'b0}}, 1'b1};
            end
            if (state_reg == hmtq_pkg::S_DONE && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // item and datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd_data;
        end
        case (state_reg)
            hmtq_pkg::S_DECODE:
            begin
                pend_reg.height_out <= '0;
                pend_reg.status     <= hmtq_pkg::STATUS_OUTSIDE;
            end
            hmtq_pkg::S_RAISE:
            begin
                pend_reg.height_out <= r_val;
                pend_reg.status     <= r_ovf ? hmtq_pkg::STATUS_SAT : hmtq_pkg::STATUS_OK;
            end
            hmtq_pkg::S_QB:  va_reg <= ram_rdata;
            hmtq_pkg::S_QC:  vb_reg <= ram_rdata;
            hmtq_pkg::S_QM1:
            begin
                vc_reg     <= ram_rdata;
                prod_b_reg <= diff_b * $signed({1'b0, dec.w_b});
            end
            hmtq_pkg::S_QM2:
            begin
                prod_c_reg <= diff_c * $signed({1'b0, dec.w_c});
            end
            hmtq_pkg::S_QSUM:
            begin
                pend_reg.height_out <= q_val;
                pend_reg.status     <= q_ovf ? hmtq_pkg::STATUS_SAT : hmtq_pkg::STATUS_OK;
            end
            hmtq_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    res_data_reg <= pend_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // an accepted item always goes to decode next
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == hmtq_pkg::S_DECODE)
        else $error("accepted item did not enter decode");

    // a finished result never overwrites one still waiting
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hmtq_pkg::S_DONE && res_valid_reg && res_stall)
        |=> state_reg == hmtq_pkg::S_DONE)
        else $error("result handed over while output register busy");

    // an outside result carries zero height
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.status == hmtq_pkg::STATUS_OUTSIDE)
        |-> res_data_reg.height_out == '0)
        else $error("outside result with nonzero height");

    // ram is written only by the clearing pass or a raise
    a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == hmtq_pkg::S_CLEAR || state_reg == hmtq_pkg::S_RAISE))
        else $error("unexpected ram write");

    // clearing pass ends after the last entry
    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hmtq_pkg::S_CLEAR && clr_last) |=> state_reg == hmtq_pkg::S_IDLE)
        else $error("clearing pass did not end");

endmodule

`default_nettype wire

[bench/heightmap_edit_and_triangle_query_tb.sv]
// self-checking bench for the heightmap edit and triangle height query block
`timescale 1ns / 1ps

module heightmap_edit_and_triangle_query_tb;

    localparam longint HEIGHT_TOP    = 64'sd8388607;
    localparam longint HEIGHT_BOTTOM = -64'sd8388608;
    localparam int     STALL_LIMIT   = 20000;
    localparam int     N_PHASES      = 10;
    localparam int     PHASE_ITEMS   = 150;
    localparam int     N_DIRECTED    = 24;
    localparam int     STEADY_PHASE  = 6;

    // short names for the table below
    localparam logic       KR     = hmtq_pkg::KIND_RAISE;
    localparam logic       KQ     = hmtq_pkg::KIND_QUERY;
    localparam logic [1:0] ST_OK  = hmtq_pkg::STATUS_OK;
    localparam logic [1:0] ST_OUT = hmtq_pkg::STATUS_OUTSIDE;
    localparam logic [1:0] ST_SAT = hmtq_pkg::STATUS_SAT;

    // one row of the directed table; res is only used when known is set
    typedef struct packed {
        hmtq_pkg::hmtq_cmd_t cmd;
        logic                known;
        hmtq_pkg::hmtq_res_t res;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_index;
    logic [hmtq_pkg::SIDE_W-1:0] cfg_data;
    logic      cmd_valid;
    logic      cmd_stall;
    hmtq_pkg::hmtq_cmd_t cmd_data;
    logic      res_valid;
    logic      res_stall;
    hmtq_pkg::hmtq_res_t res_data;

    // bench copy of the vertex grid and the grid size
    logic signed [hmtq_pkg::HEIGHT_W-1:0] vert_h [hmtq_pkg::NUM_VERTS];
    int grid_w;
    int grid_l;

    hmtq_pkg::hmtq_res_t pending_heights [$];
    int        fail_count;
    int        idle_cycles;
    bit        steady;

    // directed items: reset state, extremes, saturation, outside cases, triangle split
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{'{KQ, 16'sh0000, 16'sh0000, 24'sh000000}, 1'b1, '{24'sh000000, ST_OK}},
        '{'{KR, 16'sh0000, 16'sh0000, 24'sh7FFFFF}, 1'b1, '{24'sh7FFFFF, ST_OK}},
        '{'{KR, 16'sh0000, 16'sh0000, 24'sh000001}, 1'b1, '{24'sh7FFFFF, ST_SAT}},
        '{'{KR, 16'sh0100, 16'sh0000, 24'sh800000}, 1'b1, '{24'sh800000, ST_OK}},
        '{'{KR, 16'sh0100, 16'sh0000, 24'shFFFFFF}, 1'b1, '{24'sh800000, ST_SAT}},
        '{'{KQ, 16'sh0080, 16'sh0000, 24'sh000000}, 1'b0, '{24'sh000000, ST_OK}},
        '{'{KR, 16'shFFFF, 16'sh0000, 24'sh000010}, 1'b1, '{24'sh000000, ST_OUT}},
        '{'{KR, 16'sh0000, 16'sh8000, 24'sh000010}, 1'b1, '{24'sh000000, ST_OUT}},
        '{'{KQ, 16'sh8000, 16'sh0000, 24'sh000000}, 1'b1, '{24'sh000000, ST_OUT}},
        '{'{KQ, 16'sh0000, 16'shFFFF, 24'sh000000}, 1'b1, '{24'sh000000, ST_OUT}},
        '{'{KR, 16'sh3F00, 16'sh3F00, 24'sh000100}, 1'b1, '{24'sh000100, ST_OK}},
        '{'{KR, 16'sh4000, 16'sh0000, 24'sh000100}, 1'b1, '{24'sh000000, ST_OUT}},
        '{'{KR, 16'sh7FFF, 16'sh7FFF, 24'sh000100}, 1'b1, '{24'sh000000, ST_OUT}},
        '{'{KR, 16'sh0000, 16'sh4000, 24'sh000100}, 1'b1, '{24'sh000000, ST_OUT}},
        '{'{KQ, 16'sh3F00, 16'sh0000, 24'sh000000}, 1'b1, '{24'sh000000, ST_OUT}},
        '{'{KQ, 16'sh0000, 16'sh3F00, 24'sh000000}, 1'b1, '{24'sh000000, ST_OUT}},
        '{'{KQ, 16'sh3EFF, 16'sh3EFF, 24'sh000000}, 1'b0, '{24'sh000000, ST_OK}},
        '{'{KQ, 16'sh0080, 16'sh0080, 24'sh000000}, 1'b0, '{24'sh000000, ST_OK}},
        '{'{KQ, 16'sh0081, 16'sh0080, 24'sh000000}, 1'b0, '{24'sh000000, ST_OK}},
        '{'{KR, 16'sh0101, 16'sh0100, 24'sh123456}, 1'b0, '{24'sh000000, ST_OK}},
        '{'{KQ, 16'sh00FF, 16'sh00FF, 24'sh000000}, 1'b0, '{24'sh000000, ST_OK}},
        '{'{KQ, 16'sh0040, 16'sh00C0, 24'sh800000}, 1'b0, '{24'sh000000, ST_OK}},
        '{'{KR, 16'sh01FF, 16'sh00FF, 24'shFFFF00}, 1'b0, '{24'sh000000, ST_OK}},
        '{'{KQ, 16'sh3E00, 16'sh3E00, 24'sh7FFFFF}, 1'b0, '{24'sh000000, ST_OK}}
    };

    heightmap_edit_and_triangle_query dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // grid read, zero beyond the store
    function automatic longint vertex_at(int idx);
        return (idx < hmtq_pkg::NUM_VERTS) ? longint'(vert_h[idx]) : 64'sd0;
    endfunction

    // clip to the 24-bit height range
    function automatic hmtq_pkg::hmtq_res_t clip_height(longint v);
        hmtq_pkg::hmtq_res_t r;
        r.status = hmtq_pkg::STATUS_OK;
        if (v > HEIGHT_TOP)
        begin
            v = HEIGHT_TOP;
            r.status = hmtq_pkg::STATUS_SAT;
        end
        else if (v < HEIGHT_BOTTOM)
        begin
            v = HEIGHT_BOTTOM;
            r.status = hmtq_pkg::STATUS_SAT;
        end
        r.height_out = v[hmtq_pkg::HEIGHT_W-1:0];
        return r;
    endfunction

    // new vertex height for a raise, plane height for a query
    function automatic hmtq_pkg::hmtq_res_t predict_height(hmtq_pkg::hmtq_cmd_t c);
        hmtq_pkg::hmtq_res_t r;
        int xi;
        int zi;
        int fx;
        int fz;
        int pitch;
        int idx;
        longint v0;
        longint v1;
        longint v2;
        longint v3;
        longint acc;
        r.height_out = '0;
        r.status = hmtq_pkg::STATUS_OUTSIDE;
        if (c.pos_x < 0 || c.pos_z < 0)
            return r;
        xi = int'(c.pos_x) >>> 8;
        zi = int'(c.pos_z) >>> 8;
        fx = int'(c.pos_x[7:0]);
        fz = int'(c.pos_z[7:0]);
        pitch = grid_w + 1;
        if (c.kind == hmtq_pkg::KIND_RAISE)
        begin
            if (xi > grid_w || zi > grid_l)
                return r;
            idx = xi + zi * pitch;
            if (idx >= hmtq_pkg::NUM_VERTS)
                return r;
            r = clip_height(vertex_at(idx) + longint'(c.delta));
            vert_h[idx] = r.height_out;
            return r;
        end
        if (xi >= grid_w || zi >= grid_l)
            return r;
        idx = xi + zi * pitch;
        v0 = vertex_at(idx);
        v1 = vertex_at(idx + 1);
        v2 = vertex_at(idx + pitch);
        v3 = vertex_at(idx + pitch + 1);
        // upper triangle once fx+fz passes one cell unit
        if (fx + fz > 256)
            acc = v3 * 256 + (v2 - v3) * (256 - fx) + (v1 - v3) * (256 - fz);
        else
            acc = v0 * 256 + (v1 - v0) * fx + (v2 - v0) * fz;
        // round to nearest, ties up
        return clip_height((acc + 64'sd128) >>> 8);
    endfunction

    // random item shaped by the current grid size
    function automatic hmtq_pkg::hmtq_cmd_t random_item();
        hmtq_pkg::hmtq_cmd_t c;
        int pick;
        int x_top;
        int z_top;
        c.kind = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        x_top = (c.kind == hmtq_pkg::KIND_RAISE) ? grid_w * 256 + 255 : grid_w * 256 - 1;
        z_top = (c.kind == hmtq_pkg::KIND_RAISE) ? grid_l * 256 + 255 : grid_l * 256 - 1;
        if (pick < 75 && x_top >= 0 && z_top >= 0)
        begin
            c.pos_x = 16'($urandom_range(0, x_top));
            c.pos_z = 16'($urandom_range(0, z_top));
        end
        else if (pick < 88)
        begin
            // around the far edges
            if ($urandom_range(0, 1) == 1)
            begin
                c.pos_x = 16'(grid_w * 256 + $urandom_range(0, 767));
                c.pos_z = 16'($urandom_range(0, grid_l * 256 + 255));
            end
            else
            begin
                c.pos_x = 16'($urandom_range(0, grid_w * 256 + 255));
                c.pos_z = 16'(grid_l * 256 + $urandom_range(0, 767));
            end
        end
        else
        begin
            c.pos_x = 16'($urandom);
            c.pos_z = 16'($urandom);
        end
        case ($urandom_range(0, 9))
            0: c.delta = 24'($urandom);
            1: c.delta = ($urandom_range(0, 1) == 1) ? 24'sh7FFFFF : 24'sh800000;
            default: c.delta = 24'(int'($urandom_range(0, 131071)) - 65536);
        endcase
        return c;
    endfunction

    // append one expected result item to the scoreboard
    task automatic note_result(hmtq_pkg::hmtq_res_t r);
        pending_heights = {pending_heights, r};
    endtask

    // present one item, hold it until taken, then log its expected result
    task automatic send_cmd(hmtq_pkg::hmtq_cmd_t c, logic known,
                            hmtq_pkg::hmtq_res_t known_res);
        hmtq_pkg::hmtq_res_t pred;
        while (!steady && $urandom_range(0, 99) < 26)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        pred = predict_height(c);
        note_result(known ? known_res : pred);
    endtask

    // resize the grid once every result is back
    task automatic write_grid(int w, int l);
        cmd_valid <= 1'b0;
        while (pending_heights.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= hmtq_pkg::CFG_GRID_WIDTH;
        cfg_data  <= hmtq_pkg::SIDE_W'(w);
        @(posedge clk);
        cfg_index <= hmtq_pkg::CFG_GRID_LENGTH;
        cfg_data  <= hmtq_pkg::SIDE_W'(l);
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_w = w;
        grid_l = l;
    endtask

    // stimulus
    initial
    begin
        int phase_w [N_PHASES];
        int phase_l [N_PHASES];
        int w;
        int l;
        phase_w = '{63, 2, 0, 63, 0, 1, 63, 7, 0, 0};
        phase_l = '{63, 1, 0, 0, 63, 1, 63, 5, 0, 0};
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= hmtq_pkg::CFG_GRID_WIDTH;
        cfg_data  <= '0;
        cmd_valid <= 1'b0;
        cmd_data  <= '0;
        fail_count = 0;
        steady = 1'b0;
        grid_w = hmtq_pkg::MAX_SIDE;
        grid_l = hmtq_pkg::MAX_SIDE;
        for (int i = 0; i < hmtq_pkg::NUM_VERTS; i++)
            vert_h[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
            begin
                w = (p >= 8) ? int'($urandom_range(0, hmtq_pkg::MAX_SIDE)) : phase_w[p];
                l = (p >= 8) ? int'($urandom_range(0, hmtq_pkg::MAX_SIDE)) : phase_l[p];
                write_grid(w, l);
            end
            // one phase runs with no idling on either side
            steady = (p == STEADY_PHASE);
            if (p == 0)
                for (int r = 0; r < N_DIRECTED; r++)
                    send_cmd(directed_rows[r].cmd, directed_rows[r].known,
                             directed_rows[r].res);
            repeat (PHASE_ITEMS)
                send_cmd(random_item(), 1'b0, '0);
        end

        // drain
        cmd_valid <= 1'b0;
        while (pending_heights.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        res_stall <= !steady && ($urandom_range(0, 99) < 26);
    end

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        hmtq_pkg::hmtq_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_heights.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual height %h status %0d",
                         $time, res_data.height_out, res_data.status);
                fail_count++;
            end
            else
            begin
                want = pending_heights.pop_front();
                if (res_data.height_out !== want.height_out)
                begin
                    $display("%0t height_out mismatch: expected %h, actual %h",
                             $time, want.height_out, res_data.height_out);
                    fail_count++;
                end
                if (res_data.status !== want.status)
                begin
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, want.status, res_data.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule
